// ----- rtl/software_timer_slot_bank_top_assert.svh -----
// Assertion macros shared by the timer slot bank RTL.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef SOFTWARE_TIMER_SLOT_BANK_TOP_ASSERT_SVH
`define SOFTWARE_TIMER_SLOT_BANK_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define STSB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define STSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/stsb_pkg.sv -----
// Package for the timer slot bank: sizes, operation codes and record types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package stsb_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int COUNT_WIDTH = 32;
  localparam int IDX_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SLOT_W      = 4;
  localparam int OP_W        = 3;

  localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
  localparam logic [OP_W-1:0] OP_ENABLE  = 3'd1;
  localparam logic [OP_W-1:0] OP_TICK    = 3'd2;
  localparam logic [OP_W-1:0] OP_SERVICE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_FIRE = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic                   valid;
    logic                   enabled;
    logic                   callback;
    logic [COUNT_WIDTH-1:0] count;
    logic [COUNT_WIDTH-1:0] reload;
  } slot_rec_t;

  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic [SLOT_W-1:0]      slot_index;
    logic                   enable_value;
    logic [COUNT_WIDTH-1:0] delay;
    logic [COUNT_WIDTH-1:0] reload;
    logic                   has_callback;
    logic                   claim_open;
    logic [IDX_W-1:0]       head_slot;
  } head_ctl_t;

  typedef struct packed {
    logic fire;
    logic freed;
    logic claim;
  } head_res_t;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic              status;
    logic              freed;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/stsb_cell.sv -----
// One cell of the slot ring: holds one slot record and takes its neighbor's on shift.
// Depends on stsb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stsb_cell (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 shift_en,
  input  wire stsb_pkg::slot_rec_t  d,
  output stsb_pkg::slot_rec_t       q
);
  import stsb_pkg::*;

  slot_rec_t rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r.valid    <= 1'b0;
      rec_r.enabled  <= 1'b0;
      rec_r.callback <= 1'b0;
    end else if (shift_en) begin
      rec_r <= d;
    end
  end

  assign q = rec_r;

endmodule

`default_nettype wire

// ----- rtl/stsb_head_op.sv -----
// Update applied to the slot record at the head of the ring for the current operation.
// Depends on stsb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stsb_head_op (
  input  wire stsb_pkg::slot_rec_t rec,
  input  wire stsb_pkg::head_ctl_t ctl,
  output stsb_pkg::slot_rec_t      rec_nxt,
  output stsb_pkg::head_res_t      res
);
  import stsb_pkg::*;

  always_comb begin
    rec_nxt   = rec;
    res.fire  = 1'b0;
    res.freed = 1'b0;
    res.claim = 1'b0;
    case (ctl.op)
      OP_ADD: begin
        if (!rec.valid && ctl.claim_open) begin
          rec_nxt.valid    = 1'b1;
          rec_nxt.enabled  = 1'b0;
          rec_nxt.callback = ctl.has_callback;
          rec_nxt.count    = ctl.delay;
          rec_nxt.reload   = ctl.reload;
          res.claim        = 1'b1;
        end
      end
      OP_ENABLE: begin
        if (rec.valid && (ctl.slot_index == SLOT_W'(ctl.head_slot))) begin
          rec_nxt.enabled = ctl.enable_value;
        end
      end
      OP_TICK: begin
        if (rec.valid && rec.enabled && (rec.count != '0)) begin
          rec_nxt.count = rec.count - COUNT_WIDTH'(1);
        end
      end
      OP_SERVICE: begin
        if (rec.valid && rec.callback && (rec.count == '0)) begin
          res.fire = 1'b1;
          if (rec.reload != '0) begin
            rec_nxt.count = rec.reload;
          end else begin
            rec_nxt.valid    = 1'b0;
            rec_nxt.enabled  = 1'b0;
            rec_nxt.callback = 1'b0;
            res.freed        = 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        rec_nxt.valid    = 1'b0;
        rec_nxt.enabled  = 1'b0;
        rec_nxt.callback = 1'b0;
      end
      default: begin
        rec_nxt = rec;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/software_timer_slot_bank_top.sv -----
// Top level of the timer slot bank: slot ring, head update, sequencer and result register.
// Depends on stsb_pkg, stsb_cell, stsb_head_op and the assertion macro header.
//
// The block keeps sixteen timer slots in a ring of cells. Commands arrive as beats
// on the in_ channel; in_tuser carries the opcode (add, enable, tick, service,
// clear) and in_tdata the operands. Results leave on the out_ channel: out_tuser
// is the kind (add reply or fire), out_tlast marks the last beat caused by a
// command. Add gives one beat, service gives one beat per fired slot, other
// commands give none.
// Every command rotates the ring once, with the slot at the head updated each cycle
// unless the ring is stalled on a fire; this rotation sets the rate. A command is
// registered, the ring rotates in S_SCAN, S_FLUSH forms the add reply or marks the
// last beat, and S_DRAIN hands a held beat to the output register before S_IDLE.
// Only one command is in flight: a new beat is accepted only in S_IDLE.
// When a beat is held and the output register is full and not ready, the ring stops at
// the next slot that fires and waits; the final result register lets the next command
// be taken while a beat waits. After reset all slots are free and in_tready is high.
`timescale 1ns / 1ps
`default_nettype none

module software_timer_slot_bank_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // slot_index[3:0], enable_value[4], initial_delay[36:5], reload_period[68:37],
  // has_callback[69], zero fill [71:70]
  input  wire logic [71:0] in_tdata,
  // opcode[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // result_slot[3:0], status_code[4], slot_freed[5], zero fill [7:6]
  output logic [7:0]       out_tdata,
  // result_kind[0]
  output logic             out_tuser,
  output logic             out_tlast
);
  import stsb_pkg::*;

  `include "software_timer_slot_bank_top_assert.svh"

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_FLUSH = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       cnt_r, cnt_nxt;
  logic                   found_r, found_nxt;
  logic [IDX_W-1:0]       found_slot_r, found_slot_nxt;
  logic                   h_valid_r, h_valid_nxt;
  result_t                h_r, h_nxt;
  logic                   out_valid_r, out_valid_nxt;
  result_t                out_r, out_nxt;

  logic [OP_W-1:0]        op_r;
  logic [SLOT_W-1:0]      idx_r;
  logic                   en_val_r;
  logic [COUNT_WIDTH-1:0] delay_r;
  logic [COUNT_WIDTH-1:0] reload_r;
  logic                   cb_r;

  slot_rec_t              ring_q [NUM_SLOTS];
  slot_rec_t              head_nxt;
  head_ctl_t              ctl;
  head_res_t              res;

  logic                   accept;
  logic                   out_free;
  logic                   step_ok;
  logic                   shift_en;
  logic                   last_step;

  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign step_ok   = !(res.fire && h_valid_r && !out_free);
  assign shift_en  = (state_r == S_SCAN) && step_ok;
  assign last_step = (cnt_r == IDX_W'(NUM_SLOTS - 1));

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_tuser;
      idx_r    <= in_tdata[3:0];
      en_val_r <= in_tdata[4];
      delay_r  <= COUNT_WIDTH'(in_tdata[36:5]);
      reload_r <= COUNT_WIDTH'(in_tdata[68:37]);
      cb_r     <= in_tdata[69];
    end
  end

  always_comb begin
    ctl.op           = op_r;
    ctl.slot_index   = idx_r;
    ctl.enable_value = en_val_r;
    ctl.delay        = delay_r;
    ctl.reload       = reload_r;
    ctl.has_callback = cb_r;
    ctl.claim_open   = !found_r;
    ctl.head_slot    = cnt_r;
  end

  stsb_head_op u_head (
    .rec     (ring_q[0]),
    .ctl     (ctl),
    .rec_nxt (head_nxt),
    .res     (res)
  );

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_ring
    if (k == NUM_SLOTS - 1) begin : g_tail
      stsb_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .d        (head_nxt),
        .q        (ring_q[k])
      );
    end else begin : g_body
      stsb_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .d        (ring_q[k+1]),
        .q        (ring_q[k])
      );
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    found_nxt      = found_r;
    found_slot_nxt = found_slot_r;
    h_valid_nxt    = h_valid_r;
    h_nxt          = h_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_nxt        = out_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SCAN;
          cnt_nxt   = '0;
          found_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        if (step_ok) begin
          cnt_nxt = last_step ? '0 : cnt_r + IDX_W'(1);
          if (last_step) begin
            state_nxt = S_FLUSH;
          end
          if (res.claim) begin
            found_nxt      = 1'b1;
            found_slot_nxt = cnt_r;
          end
          if (res.fire) begin
            if (h_valid_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = h_r;
            end
            h_valid_nxt = 1'b1;
            h_nxt.kind   = KIND_FIRE;
            h_nxt.slot   = SLOT_W'(cnt_r);
            h_nxt.status = STATUS_OK;
            h_nxt.freed  = res.freed;
            h_nxt.last   = 1'b0;
          end
        end
      end
      S_FLUSH: begin
        if (op_r == OP_ADD) begin
          h_valid_nxt  = 1'b1;
          h_nxt.kind   = KIND_ADD;
          h_nxt.slot   = found_r ? SLOT_W'(found_slot_r) : '0;
          h_nxt.status = found_r ? STATUS_OK : STATUS_FULL;
          h_nxt.freed  = 1'b0;
          h_nxt.last   = 1'b1;
          state_nxt    = S_DRAIN;
        end else if (h_valid_r) begin
          h_nxt.last = 1'b1;
          state_nxt  = S_DRAIN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = h_r;
          h_valid_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      h_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
      h_valid_r   <= h_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_slot_r <= found_slot_nxt;
    h_r          <= h_nxt;
    out_r        <= out_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r.freed, out_r.status, out_r.slot};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;

  `STSB_ASSERT_IMPL(a_idle_no_held, state_r == S_IDLE, !h_valid_r, "held beat left at idle")
  `STSB_ASSERT_IMPL(a_flush_aligned, state_r == S_FLUSH, cnt_r == '0, "ring not realigned")
  `STSB_ASSERT_IMPL(a_scan_not_last, (state_r == S_SCAN) && h_valid_r, !h_r.last,
                    "last flag set during scan")
  `STSB_ASSERT_NEXT(a_stall_holds, (state_r == S_SCAN) && !step_ok,
                    $stable(cnt_r) && (state_r == S_SCAN), "ring moved while stalled")

endmodule

`default_nettype wire

// ----- tb/software_timer_slot_bank_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for software_timer_slot_bank_top. Command beats go in with random pacing.
// Each result beat is checked against a slot-bank predictor kept here. Depends on stsb_pkg and the RTL.

module software_timer_slot_bank_top_tb;
  import stsb_pkg::*;

  localparam int RANDOM_CMDS    = 405;
  localparam int HOLD_AT_BEAT   = 60;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 60;
  localparam int RESET_CYCLES   = 10;

  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic [SLOT_W-1:0]      slot_index;
    logic                   enable_value;
    logic [COUNT_WIDTH-1:0] delay;
    logic [COUNT_WIDTH-1:0] reload;
    logic                   has_callback;
  } timer_cmd_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [71:0] in_tdata   = '0;
  logic [2:0]  in_tuser   = '0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  timer_cmd_t pending_cmds[$];
  result_t    expected_results[$];
  slot_rec_t  slot_model[NUM_SLOTS];
  timer_cmd_t cur_cmd;

  int send_wait    = 0;
  int send_burst   = 0;
  int recv_wait    = 0;
  int recv_burst   = 0;
  int quiet_cycles = 0;
  int error_count  = 0;
  int cmds_sent    = 0;
  int beats_seen   = 0;
  int adds_seen    = 0;
  int full_seen    = 0;
  int fires_seen   = 0;
  int frees_seen   = 0;

  software_timer_slot_bank_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int idle_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) begin
      burst = 12;
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  function automatic timer_cmd_t random_cmd();
    timer_cmd_t c;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 26) c.op = OP_ADD;
    else if (pick < 46) c.op = OP_ENABLE;
    else if (pick < 76) c.op = OP_TICK;
    else if (pick < 94) c.op = OP_SERVICE;
    else if (pick < 97) c.op = OP_CLEAR;
    else c.op = OP_FIRST_UNUSED + OP_W'($urandom_range(0, 2));
    c.slot_index   = $urandom_range(0, 1) ? SLOT_W'($urandom_range(0, 15))
                                          : SLOT_W'($urandom_range(0, 5));
    c.enable_value = ($urandom_range(0, 4) != 0);
    pick = $urandom_range(0, 19);
    if (pick < 14) c.delay = $urandom_range(0, 4);
    else if (pick < 17) c.delay = $urandom_range(0, 30);
    else if (pick < 18) c.delay = '1;
    else c.delay = $urandom;
    pick = $urandom_range(0, 19);
    if (pick < 9) c.reload = '0;
    else if (pick < 16) c.reload = $urandom_range(1, 4);
    else if (pick < 18) c.reload = $urandom;
    else if (pick < 19) c.reload = '1;
    else c.reload = $urandom_range(1, 40);
    c.has_callback = ($urandom_range(0, 6) != 0);
    return c;
  endfunction

  // Updates the slot bank copy for one accepted command and queues the beats it must cause.
  task automatic predict_command(input timer_cmd_t c);
    logic [NUM_SLOTS-1:0] ready_mask;
    int                   free_slot;
    int                   i;
    result_t              r;
    free_slot  = -1;
    ready_mask = '0;
    case (c.op)
      OP_ADD: begin
        for (i = NUM_SLOTS - 1; i >= 0; i--) begin
          if (!slot_model[i].valid) free_slot = i;
        end
        r.kind  = KIND_ADD;
        r.freed = 1'b0;
        r.last  = 1'b1;
        if (free_slot >= 0) begin
          slot_model[free_slot].valid    = 1'b1;
          slot_model[free_slot].enabled  = 1'b0;
          slot_model[free_slot].callback = c.has_callback;
          slot_model[free_slot].count    = c.delay;
          slot_model[free_slot].reload   = c.reload;
          r.slot   = SLOT_W'(free_slot);
          r.status = STATUS_OK;
        end else begin
          r.slot   = '0;
          r.status = STATUS_FULL;
        end
        expected_results.push_back(r);
      end
      OP_ENABLE: begin
        if (slot_model[c.slot_index].valid) slot_model[c.slot_index].enabled = c.enable_value;
      end
      OP_TICK: begin
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (slot_model[i].valid && slot_model[i].enabled && slot_model[i].count != '0) begin
            slot_model[i].count = slot_model[i].count - 1'b1;
          end
        end
      end
      OP_SERVICE: begin
        for (i = 0; i < NUM_SLOTS; i++) begin
          ready_mask[i] = slot_model[i].valid && slot_model[i].callback &&
                          slot_model[i].count == '0;
        end
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (ready_mask[i]) begin
            r.kind   = KIND_FIRE;
            r.slot   = SLOT_W'(i);
            r.status = STATUS_OK;
            r.freed  = (slot_model[i].reload == '0);
            r.last   = ((ready_mask >> (i + 1)) == '0);
            if (r.freed) begin
              slot_model[i].valid    = 1'b0;
              slot_model[i].enabled  = 1'b0;
              slot_model[i].callback = 1'b0;
            end else begin
              slot_model[i].count = slot_model[i].reload;
            end
            expected_results.push_back(r);
          end
        end
      end
      OP_CLEAR: begin
        for (i = 0; i < NUM_SLOTS; i++) begin
          slot_model[i].valid    = 1'b0;
          slot_model[i].enabled  = 1'b0;
          slot_model[i].callback = 1'b0;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  task automatic check_beat();
    result_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result beat: kind %0d slot %0d", out_tuser, out_tdata[3:0]);
      error_count++;
    end else begin
      want = expected_results.pop_front();
      compare_field("result_kind", want.kind, out_tuser);
      compare_field("result_slot", want.slot, out_tdata[3:0]);
      compare_field("status_code", want.status, out_tdata[4]);
      compare_field("slot_freed", want.freed, out_tdata[5]);
      compare_field("last_result", want.last, out_tlast);
    end
    if (out_tuser == KIND_FIRE) begin
      fires_seen++;
      if (out_tdata[5]) frees_seen++;
    end else begin
      adds_seen++;
      if (out_tdata[4] == STATUS_FULL) full_seen++;
    end
  endtask

  always @(posedge clk) begin : drive_cmds
    logic offer;
    offer = in_tvalid;
    if (!rst_n) begin
      offer = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_command(cur_cmd);
        cmds_sent++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          in_tuser <= cur_cmd.op;
          in_tdata <= {2'b00, cur_cmd.has_callback, cur_cmd.reload, cur_cmd.delay,
                       cur_cmd.enable_value, cur_cmd.slot_index};
          offer     = 1'b1;
          send_wait = idle_gap(send_burst);
        end
      end
    end
    in_tvalid <= offer;
  end

  // After a fixed number of beats the receiver holds off long enough for the block to back up.
  always @(posedge clk) begin : collect_results
    logic rdy;
    rdy = out_tready;
    if (!rst_n) begin
      rdy = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_beat();
        beats_seen++;
        recv_wait = (beats_seen == HOLD_AT_BEAT) ? HOLD_CYCLES : idle_gap(recv_burst);
        if (recv_wait > 0) rdy = 1'b0;
      end else if (rdy && $urandom_range(0, 15) == 0) begin
        recv_wait = idle_gap(recv_burst);
        if (recv_wait > 0) rdy = 1'b0;
      end
      if (!rdy) begin
        if (recv_wait == 0) rdy = 1'b1;
        else recv_wait--;
      end
    end
    out_tready <= rdy;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Timeout: %0d commands unsent, %0d results outstanding.",
               pending_cmds.size(), expected_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    timer_cmd_t c;
    int         i;
    int         counted;
    counted = 0;

    for (i = 0; i < NUM_SLOTS; i++) begin
      slot_model[i] = '0;
    end

    c    = random_cmd();
    c.op = OP_CLEAR;
    pending_cmds.push_back(c);
    // Fill every slot with a ready timer; even slots are one-shot, odd ones periodic.
    for (i = 0; i < NUM_SLOTS; i++) begin
      c              = random_cmd();
      c.op           = OP_ADD;
      c.delay        = '0;
      c.has_callback = 1'b1;
      c.reload       = (i % 2 == 0) ? '0 : (i == 1) ? '1 : COUNT_WIDTH'($urandom_range(1, 9));
      pending_cmds.push_back(c);
    end
    c              = random_cmd();
    c.op           = OP_ADD;
    c.delay        = '1;
    c.reload       = '1;
    c.has_callback = 1'b0;
    pending_cmds.push_back(c);
    c    = random_cmd();
    c.op = OP_SERVICE;
    pending_cmds.push_back(c);
    c              = random_cmd();
    c.op           = OP_ENABLE;
    c.slot_index   = '1;
    c.enable_value = 1'b1;
    pending_cmds.push_back(c);
    c.slot_index = '0;
    pending_cmds.push_back(c);
    for (i = OP_FIRST_UNUSED; i <= OP_LAST_UNUSED; i++) begin
      c    = random_cmd();
      c.op = OP_W'(i);
      pending_cmds.push_back(c);
    end
    c    = random_cmd();
    c.op = OP_TICK;
    pending_cmds.push_back(c);

    while (counted < RANDOM_CMDS) begin
      c = random_cmd();
      pending_cmds.push_back(c);
      if (c.op <= OP_CLEAR) counted++;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() > 0 || in_tvalid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d commands and %0d result beats: %0d add replies (%0d full),",
             cmds_sent, beats_seen, adds_seen, full_seen);
    $display("%0d fires (%0d one-shot frees), with a long receiver stall after beat %0d.",
             fires_seen, frees_seen, HOLD_AT_BEAT);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
